>>> rtl/core/fnvbi_pkg.sv
// ----------------------------------------------------------------------------
// fnvbi_pkg
// Shared types and constants of the FNV-1 bucket index unit: hash constants,
// the prime bucket table, register indexes and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package fnvbi_pkg;

   localparam int unsigned HASH_W    = 32;
   localparam int unsigned BUCKET_W  = 31;
   localparam int unsigned KEY_W_MAX = 64;
   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned CSR_DAT_W = 32;

   localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;
   localparam logic [HASH_W-1:0] FNV_MULT  = 32'd16777619;

   localparam int unsigned TABLE_SIZE = 26;

   typedef logic [BUCKET_W-1:0] prime_type;

   localparam prime_type PRIME_TABLE [TABLE_SIZE] = '{
      31'd53,        31'd97,        31'd193,       31'd389,
      31'd769,       31'd1543,      31'd3079,      31'd6151,
      31'd12289,     31'd24593,     31'd49157,     31'd98317,
      31'd196613,    31'd393241,    31'd786433,    31'd1572869,
      31'd3145739,   31'd6291469,   31'd12582917,  31'd25165843,
      31'd50331653,  31'd100663319, 31'd201326611, 31'd402653189,
      31'd805306457, 31'd1610612741
   };

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_KIND          = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ESTIMATED_ENTRIES = 1'd1;

   // key kinds
   localparam logic KIND_INTEGER = 1'b0;
   localparam logic KIND_STRING  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_HASH,
      ST_MOD,
      ST_DONE
   } state_type;

endpackage : fnvbi_pkg

`default_nettype wire

>>> rtl/core/fnv1_hash_bucket_index_unit.sv
// ----------------------------------------------------------------------------
// fnv1_hash_bucket_index_unit
// FNV-1 32-bit hash of integer or string keys and its bucket in a
// prime-sized table picked from the configured entry estimate.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake              payload
//  -------  ---  ---------------------  --------------------------------------
//  req      in   req_valid / req_stall  req_key_word[63:0], req_char_byte[7:0]
//  rsp      out  rsp_valid / rsp_stall  rsp_hash_value[31:0],
//                                       rsp_bucket_index[30:0]
//  csr      in   csr_we (no wait)       csr_index[0], csr_wdata[31:0]
//
//  Integer beat: accept, one hash round per key byte, the remainder steps,
//    then the load into the output slot; the shared remainder unit and the
//    single hash round unit set its length.
//  String beat with nonzero char: hashed in the accept cycle, next beat
//    accepted right after. Ending zero char: hash goes to the remainder unit.
//  Reset clears control, running hash to the offset basis, buckets to 53.
//  A result waiting under rsp_stall does not block the next req beat; only
//  loading the following result waits for the output slot.
// ----------------------------------------------------------------------------
`default_nettype none

module fnv1_hash_bucket_index_unit #(
   parameter int unsigned KEY_BYTES   = 8,
   parameter int unsigned PRIME_COUNT = 26
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request channel
   input  wire logic                            req_valid,
   output      logic                            req_stall,
   input  wire logic [fnvbi_pkg::KEY_W_MAX-1:0] req_key_word,
   input  wire logic [7:0]                      req_char_byte,
   // result channel
   output      logic                            rsp_valid,
   input  wire logic                            rsp_stall,
   output      logic [fnvbi_pkg::HASH_W-1:0]    rsp_hash_value,
   output      logic [fnvbi_pkg::BUCKET_W-1:0]  rsp_bucket_index,
   // configuration
   input  wire logic                            csr_we,
   input  wire logic [fnvbi_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [fnvbi_pkg::CSR_DAT_W-1:0] csr_wdata
);
   import fnvbi_pkg::*;

   localparam int unsigned KEY_W  = 8 * KEY_BYTES;
   localparam int unsigned BYTE_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

   state_type              state_ff, state_in;
   logic                   key_kind_ff, key_kind_in;
   prime_type              bucket_count_ff, bucket_count_in;
   logic [HASH_W-1:0]      running_hash_ff, running_hash_in;
   logic [HASH_W-1:0]      work_hash_ff, work_hash_in;
   logic [KEY_W-1:0]       key_ff, key_in;
   logic [BYTE_W-1:0]      byte_cnt_ff, byte_cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [HASH_W-1:0]      rsp_hash_ff, rsp_hash_in;
   logic [BUCKET_W-1:0]    rsp_bucket_ff, rsp_bucket_in;

   logic                   req_accept;
   logic                   out_free;
   logic [HASH_W-1:0]      round_h, round_b, round_out;
   logic [HASH_W-1:0]      char_sext;
   prime_type              picked_prime;
   logic                   mod_start;
   logic [HASH_W-1:0]      mod_dividend;
   logic                   mod_done;
   logic [BUCKET_W-1:0]    mod_rem;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   // signed char semantics
   assign char_sext  = {{(HASH_W-8){req_char_byte[7]}}, req_char_byte};

   fnvbi_hash_round u_round (
      .hash_i (round_h),
      .data_i (round_b),
      .hash_o (round_out)
   );

   fnvbi_prime_pick #(
      .PRIME_COUNT (PRIME_COUNT)
   ) u_pick (
      .want_i  (csr_wdata),
      .prime_o (picked_prime)
   );

   fnvbi_mod_unit u_mod (
      .clock      (clock),
      .reset      (reset),
      .start_i    (mod_start),
      .dividend_i (mod_dividend),
      .divisor_i  (bucket_count_ff),
      .done_o     (mod_done),
      .rem_o      (mod_rem)
   );

   // sequencer: next state and datapath controls
   always_comb begin
      state_in        = state_ff;
      key_kind_in     = key_kind_ff;
      bucket_count_in = bucket_count_ff;
      running_hash_in = running_hash_ff;
      work_hash_in    = work_hash_ff;
      key_in          = key_ff;
      byte_cnt_in     = byte_cnt_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_hash_in     = rsp_hash_ff;
      rsp_bucket_in   = rsp_bucket_ff;
      round_h         = running_hash_ff;
      round_b         = char_sext;
      mod_start       = 1'b0;
      mod_dividend    = work_hash_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (key_kind_ff == KIND_INTEGER) begin
                  work_hash_in = FNV_BASIS;
                  key_in       = req_key_word[KEY_W-1:0];
                  byte_cnt_in  = '0;
                  state_in     = ST_HASH;
               end else if (req_char_byte == 8'd0) begin
                  // end of string: hand the running hash to the remainder unit
                  work_hash_in    = running_hash_ff;
                  running_hash_in = FNV_BASIS;
                  mod_start       = 1'b1;
                  mod_dividend    = running_hash_ff;
                  state_in        = ST_MOD;
               end else begin
                  running_hash_in = round_out;
               end
            end
         end
         ST_HASH: begin
            round_h      = work_hash_ff;
            round_b      = {{(HASH_W-8){1'b0}}, key_ff[7:0]};
            work_hash_in = round_out;
            key_in       = key_ff >> 8;
            byte_cnt_in  = byte_cnt_ff + BYTE_W'(1);
            if (byte_cnt_ff == BYTE_W'(KEY_BYTES - 1)) begin
               mod_start    = 1'b1;
               mod_dividend = round_out;
               state_in     = ST_MOD;
            end
         end
         ST_MOD: begin
            if (mod_done) begin
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_hash_in   = work_hash_ff;
                  rsp_bucket_in = mod_rem;
                  state_in      = ST_IDLE;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            // remainder held in the unit until the slot frees
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_hash_in   = work_hash_ff;
               rsp_bucket_in = mod_rem;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_we) begin
         case (csr_index)
            CSR_KEY_KIND: begin
               key_kind_in     = csr_wdata[0];
               running_hash_in = FNV_BASIS;
            end
            CSR_ESTIMATED_ENTRIES: begin
               bucket_count_in = picked_prime;
            end
            default: begin
               key_kind_in = key_kind_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         key_kind_ff     <= KIND_INTEGER;
         bucket_count_ff <= PRIME_TABLE[0];
         running_hash_ff <= FNV_BASIS;
         byte_cnt_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         key_kind_ff     <= key_kind_in;
         bucket_count_ff <= bucket_count_in;
         running_hash_ff <= running_hash_in;
         byte_cnt_ff     <= byte_cnt_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      work_hash_ff  <= work_hash_in;
      key_ff        <= key_in;
      rsp_hash_ff   <= rsp_hash_in;
      rsp_bucket_ff <= rsp_bucket_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hash_value   = rsp_hash_ff;
   assign rsp_bucket_index = rsp_bucket_ff;

`ifndef SYNTH
   a_start_src : assert property (@(posedge clock) disable iff (reset)
      mod_start |-> (state_ff == ST_IDLE || state_ff == ST_HASH))
      else $error("remainder start from wrong state");
   a_done_in_mod : assert property (@(posedge clock) disable iff (reset)
      mod_done |-> (state_ff == ST_MOD))
      else $error("remainder done outside the wait state");
   a_done_loads : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && out_free) |=> rsp_valid)
      else $error("pending result not loaded into free slot");
   a_char_stays_idle : assert property (@(posedge clock) disable iff (reset)
      (req_accept && key_kind_ff == KIND_STRING && req_char_byte != 8'd0)
      |=> (state_ff == ST_IDLE))
      else $error("string character left the idle state");
`endif

endmodule : fnv1_hash_bucket_index_unit

`default_nettype wire

>>> rtl/core/fnvbi_hash_round.sv
// ----------------------------------------------------------------------------
// fnvbi_hash_round
// One FNV-1 round: multiply by the FNV prime mod 2^32, then XOR in a byte.
// ----------------------------------------------------------------------------
`default_nettype none

module fnvbi_hash_round (
   input  wire logic [fnvbi_pkg::HASH_W-1:0] hash_i,
   input  wire logic [fnvbi_pkg::HASH_W-1:0] data_i,
   output      logic [fnvbi_pkg::HASH_W-1:0] hash_o
);
   import fnvbi_pkg::*;

   logic [HASH_W-1:0] product;

   // constant multiplier: 2^24 + 2^8 + 0x93, shift-add in synthesis
   assign product = hash_i * FNV_MULT;
   assign hash_o  = product ^ data_i;

endmodule : fnvbi_hash_round

`default_nettype wire

>>> rtl/core/fnvbi_prime_pick.sv
// ----------------------------------------------------------------------------
// fnvbi_prime_pick
// Smallest table prime at or above the estimate; largest prime otherwise.
// ----------------------------------------------------------------------------
`default_nettype none

module fnvbi_prime_pick #(
   parameter int unsigned PRIME_COUNT = 26
) (
   input  wire logic [fnvbi_pkg::CSR_DAT_W-1:0] want_i,
   output      fnvbi_pkg::prime_type            prime_o
);
   import fnvbi_pkg::*;

   // parallel compares against constants, lowest hit wins
   always_comb begin
      prime_o = PRIME_TABLE[PRIME_COUNT-1];
      for (int i = PRIME_COUNT - 1; i >= 0; i--) begin
         if ({1'b0, PRIME_TABLE[i]} >= want_i) begin
            prime_o = PRIME_TABLE[i];
         end
      end
   end

endmodule : fnvbi_prime_pick

`default_nettype wire

>>> rtl/core/fnvbi_mod_unit.sv
// ----------------------------------------------------------------------------
// fnvbi_mod_unit
// Restoring remainder unit: 32-bit dividend mod 31-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fnvbi_mod_unit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start_i,
   input  wire logic [fnvbi_pkg::HASH_W-1:0]   dividend_i,
   input  wire fnvbi_pkg::prime_type           divisor_i,
   output      logic                           done_o,
   output      logic [fnvbi_pkg::BUCKET_W-1:0] rem_o
);
   import fnvbi_pkg::*;

   localparam int unsigned CNT_W = $clog2(HASH_W);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [HASH_W-1:0]    dvd_ff, dvd_in;
   prime_type            div_ff, div_in;
   logic [BUCKET_W-1:0]  rem_ff, rem_in;

   logic [HASH_W-1:0]    trial;
   logic [HASH_W:0]      diff;

   assign trial = {rem_ff, dvd_ff[HASH_W-1]};
   assign diff  = {1'b0, trial} - {2'b00, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      if (start_i) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend_i;
         div_in  = divisor_i;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[HASH_W-2:0], 1'b0};
         rem_in = diff[HASH_W] ? trial[BUCKET_W-1:0] : diff[BUCKET_W-1:0];
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(HASH_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign done_o = done_ff;
   assign rem_o  = rem_ff;

`ifndef SYNTH
   a_rem_below_div : assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < div_ff))
      else $error("remainder not below divisor");
   a_done_pulse : assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("done held more than one cycle");
   a_start_busy : assert property (@(posedge clock) disable iff (reset)
      start_i |=> busy_ff)
      else $error("start did not launch the unit");
`endif

endmodule : fnvbi_mod_unit

`default_nettype wire
